[rtl/lphj_pkg.sv]
`default_nettype none

package lphj_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int KEY_WIDTH_DEF   = 64;
    localparam int ROW_W           = 32;
    localparam int HASH_W          = 64;
    localparam int MIX_SHIFT       = 33;
    localparam int MIN_BITS        = 4;

    localparam logic [3:0] TABLE_BITS_RST = 4'd12;

    localparam logic [HASH_W-1:0] MIX_C1 = 64'hff51afd7ed558ccd;
    localparam logic [HASH_W-1:0] MIX_C2 = 64'hc4ceb93e1a85ec53;

    localparam logic ACT_BUILD = 1'b0;
    localparam logic ACT_PROBE = 1'b1;

    typedef struct packed {
        logic             found;
        logic [ROW_W-1:0] match_row;
        logic             status;
    } t_result;

endpackage

`default_nettype wire

[rtl/lphj_ram.sv]
`default_nettype none

module lphj_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[rtl/lphj_hash.sv]
`default_nettype none

module lphj_hash
    import lphj_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [HASH_W-1:0] i_key,
    output logic                   o_done,
    output logic      [HASH_W-1:0] o_hash
);

    localparam int HALF = HASH_W / 2;

    logic              r_busy;
    logic              r_done;
    logic [2:0]        r_step;
    logic [HASH_W-1:0] r_h;
    logic [HASH_W-1:0] r_acc;
    logic [HASH_W-1:0] r_prod;

    logic [HASH_W-1:0] mul_c;
    logic [HALF-1:0]   mul_a;
    logic [HALF-1:0]   mul_b;
    logic [HASH_W-1:0] mul_p;
    logic [HASH_W-1:0] sum;
    logic [1:0]        sub;

    // step[2] selects the constant, step[1:0] walks the partial products
    assign sub   = r_step[1:0];
    assign mul_c = r_step[2] ? MIX_C2 : MIX_C1;
    assign mul_a = (sub == 2'd2) ? r_h[HASH_W-1:HALF] : r_h[HALF-1:0];
    assign mul_b = (sub == 2'd1) ? mul_c[HASH_W-1:HALF] : mul_c[HALF-1:0];
    assign mul_p = mul_a * mul_b;
    assign sum   = r_acc + {r_prod[HALF-1:0], {HALF{1'b0}}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd7) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_h <= i_key ^ (i_key >> MIX_SHIFT);
        end else if (r_busy) begin
            r_prod <= mul_p;
            case (sub)
                2'd0: r_acc <= r_acc;
                2'd1: r_acc <= r_prod;
                2'd2: r_acc <= sum;
                default: r_h <= sum ^ (sum >> MIX_SHIFT);
            endcase
        end
    end

    assign o_done = r_done;
    assign o_hash = r_h;

endmodule

`default_nettype wire

[rtl/lphj_walk.sv]
`default_nettype none

module lphj_walk
    import lphj_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [3:0]           i_table_bits,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic                 i_action,
    input  wire logic [KEY_WIDTH-1:0] i_key,
    input  wire logic [ROW_W-1:0]     i_row_id,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output t_result                   o_res
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int WORD_W = 1 + KEY_WIDTH + ROW_W;
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(TABLE_DEPTH - 1);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_wstate;

    t_wstate              r_state, n_state;
    logic [ADDR_W-1:0]    r_clr, n_clr;
    logic [ADDR_W-1:0]    r_pos, n_pos;
    logic [ADDR_W-1:0]    r_cnt, n_cnt;
    logic                 r_action, n_action;
    logic [KEY_WIDTH-1:0] r_key, n_key;
    logic [ROW_W-1:0]     r_row, n_row;
    t_result              r_res, n_res;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_W-1:0]    ram_wdata;
    logic [WORD_W-1:0]    ram_rdata;
    logic                 rd_valid;
    logic [KEY_WIDTH-1:0] rd_key;
    logic [ROW_W-1:0]     rd_row;

    logic                 hash_start;
    logic                 hash_done;
    logic [HASH_W-1:0]    hash_val;

    logic [4:0]           eff_bits;
    logic [ADDR_W-1:0]    mask;

    // clamp the slot count to what the memory holds and to at least MIN_BITS
    always_comb begin
        if ({1'b0, i_table_bits} > 5'(ADDR_W)) begin
            eff_bits = 5'(ADDR_W);
        end else begin
            eff_bits = {1'b0, i_table_bits};
        end
        if (eff_bits < 5'(MIN_BITS)) begin
            eff_bits = 5'(MIN_BITS);
        end
        for (int i = 0; i < ADDR_W; i++) begin
            mask[i] = (5'(i) < eff_bits);
        end
    end

    assign rd_valid = ram_rdata[WORD_W-1];
    assign rd_key   = ram_rdata[ROW_W +: KEY_WIDTH];
    assign rd_row   = ram_rdata[ROW_W-1:0];

    lphj_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (hash_start),
        .i_key   (64'(i_key)),
        .o_done  (hash_done),
        .o_hash  (hash_val)
    );

    lphj_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_clr      = r_clr;
        n_pos      = r_pos;
        n_cnt      = r_cnt;
        n_action   = r_action;
        n_key      = r_key;
        n_row      = r_row;
        n_res      = r_res;
        ram_we     = 1'b0;
        ram_waddr  = r_pos;
        ram_wdata  = {1'b1, r_key, r_row};
        hash_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr;
                ram_wdata = '0;
                n_clr     = r_clr + ADDR_W'(1);
                if (r_clr == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_action   = i_action;
                    n_key      = i_key;
                    n_row      = i_row_id;
                    hash_start = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_pos   = hash_val[ADDR_W-1:0] & mask;
                    n_cnt   = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                n_res   = '0;
                n_state = S_DONE;
                if (!rd_valid) begin
                    // free slot: insert lands here, probe misses
                    ram_we = (r_action == ACT_BUILD);
                end else if (r_action == ACT_PROBE && rd_key == r_key) begin
                    n_res.found     = 1'b1;
                    n_res.match_row = rd_row;
                end else if (r_cnt == mask) begin
                    // full lap without a free slot
                    n_res.status = (r_action == ACT_BUILD);
                end else begin
                    n_pos   = (r_pos + ADDR_W'(1)) & mask;
                    n_cnt   = r_cnt + ADDR_W'(1);
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_cnt    <= n_cnt;
        r_action <= n_action;
        r_key    <= n_key;
        r_row    <= n_row;
        r_res    <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    a_write_only_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && r_state != S_CLEAR) |-> (r_action == ACT_BUILD))
        else $error("table write outside clearing by a probe");

    a_found_only_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.found) |-> (r_action == ACT_PROBE))
        else $error("found flag on an insert");

    a_status_only_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status) |-> (r_action == ACT_BUILD))
        else $error("full status on a probe");

    a_miss_row_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && !o_res.found) |-> (o_res.match_row == '0))
        else $error("match row set without a hit");

endmodule

`default_nettype wire

[rtl/linear_probe_hash_join.sv]
// the home slot is read first, then one table read per further slot on the chain
// the key hash runs on a single shared 32x32 multiplier
// one item in flight at a time: the next item is accepted once the last result
//   has moved into the output register
// reset: table_bits returns to 12, then a clearing pass empties all TABLE_DEPTH
//   slots before the first item is accepted (config writes still taken)
`default_nettype none

module linear_probe_hash_join
    import lphj_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH   = KEY_WIDTH_DEF
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire logic [3:0]              i_cfg_data,
    input  wire logic                    i_valid,
    output logic                         o_ready,
    input  wire logic                    i_action,
    input  wire logic signed [63:0]      i_key,
    input  wire logic [ROW_W-1:0]        i_row_id,
    output logic                         o_valid,
    input  wire logic                    i_ready,
    output logic                         o_found,
    output logic      [ROW_W-1:0]        o_match_row,
    output logic                         o_status
);

    logic [3:0] r_table_bits;
    logic       r_out_valid;
    t_result    r_out;
    logic       res_valid;
    logic       res_ready;
    t_result    res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_bits <= TABLE_BITS_RST;
        end else if (i_cfg_valid) begin
            r_table_bits <= i_cfg_data;
        end
    end

    lphj_walk #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_WIDTH   (KEY_WIDTH)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_table_bits (r_table_bits),
        .i_in_valid   (i_valid),
        .o_in_ready   (o_ready),
        .i_action     (i_action),
        .i_key        (i_key[KEY_WIDTH-1:0]),
        .i_row_id     (i_row_id),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res)
    );

    // output register frees the walker while a result waits downstream
    assign res_ready = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_found     = r_out.found;
    assign o_match_row = r_out.match_row;
    assign o_status    = r_out.status;

endmodule

`default_nettype wire
